### hw/rtl/car_pkg.sv
// Shared constants, types and helpers for the comb/all-pass reverberator.
package car_pkg;

    localparam int COMB_COUNT_DEF         = 4;
    localparam int COMB_MAX_LENGTH_DEF    = 2048;
    localparam int ALLPASS_COUNT_DEF      = 2;
    localparam int ALLPASS_MAX_LENGTH_DEF = 1024;

    localparam int MEM_W = 24;
    localparam int CFG_W = 17;

    localparam logic [16:0] UNITY      = 17'd65536;
    localparam logic [16:0] MIX_GAIN   = 17'd9830;
    localparam logic [16:0] DAMP_SPAN  = 17'd58982;
    localparam logic [16:0] DAMP_BASE  = 17'd6554;

    // register indexes
    localparam logic [1:0] REG_MIX   = 2'd0;
    localparam logic [1:0] REG_DECAY = 2'd1;
    localparam logic [1:0] REG_DAMP  = 2'd2;

    // shared multiply-accumulate command
    typedef struct packed {
        logic               clr;   // start new accumulation
        logic               en;    // add product
        logic signed [27:0] a;
        logic signed [17:0] b;
    } t_mac_cmd;

    function automatic logic [16:0] clamp_unity(input logic [16:0] v);
        clamp_unity = (v > UNITY) ? UNITY : v;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        if (v > 48'sd8388607)       sat24 = 24'sh7fffff;
        else if (v < -48'sd8388608) sat24 = 24'sh800000;
        else                        sat24 = v[23:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767)       sat16 = 16'sh7fff;
        else if (v < -48'sd32768) sat16 = 16'sh8000;
        else                      sat16 = v[15:0];
    endfunction

endpackage

### hw/rtl/comb_allpass_reverb.sv
// Top level: sequenced comb/all-pass reverberator around one shared MAC.
// Each item is worked through in turn on the shared MAC and one port per memory; when the
// smoothed mix is zero, the input sample goes straight to the output, skipping both filters.
// s_axis_tready is low while an item is in work, so a new item is taken only once the last is sent.
// Reset (synchronous, active low) sweeps both delay memories to zero, one entry per cycle
// across the larger memory depth, before the first item.
module comb_allpass_reverb
    import car_pkg::*;
#(
    parameter int COMB_COUNT         = COMB_COUNT_DEF,
    parameter int COMB_MAX_LENGTH    = COMB_MAX_LENGTH_DEF,
    parameter int ALLPASS_COUNT      = ALLPASS_COUNT_DEF,
    parameter int ALLPASS_MAX_LENGTH = ALLPASS_MAX_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CA_W = $clog2(COMB_COUNT * COMB_MAX_LENGTH);
    localparam int AA_W = $clog2(ALLPASS_COUNT * ALLPASS_MAX_LENGTH);
    localparam int CP_W = $clog2(COMB_MAX_LENGTH);
    localparam int AP_W = $clog2(ALLPASS_MAX_LENGTH);
    localparam int CI_W = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
    localparam int AI_W = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;
    localparam int CLR_N = (COMB_COUNT * COMB_MAX_LENGTH > ALLPASS_COUNT * ALLPASS_MAX_LENGTH)
                         ? COMB_COUNT * COMB_MAX_LENGTH : ALLPASS_COUNT * ALLPASS_MAX_LENGTH;
    localparam int CLR_W = $clog2(CLR_N + 1);

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_MIX = 4'd2, S_MIXW = 4'd3,
                           S_CRD = 4'd4, S_CLP = 4'd5, S_CLPW = 4'd6, S_CFB = 4'd7,
                           S_CFBW = 4'd8, S_ARD = 4'd9, S_AWR = 4'd10, S_OUT = 4'd11,
                           S_OUTW = 4'd12, S_SEND = 4'd13, S_COEF = 4'd14, S_COEFW = 4'd15;

    logic [3:0]  r_state;
    logic [2:0]  r_wait;
    logic [16:0] r_mix, r_decay, r_damp, r_smix, r_d, r_fb;
    logic signed [15:0] r_x, r_y;
    logic [15:0] r_dout;
    logic signed [23:0] r_tap, r_lp [COMB_COUNT];
    logic signed [27:0] r_wet;
    logic [CP_W-1:0] r_cpos [COMB_COUNT];
    logic [AP_W-1:0] r_apos [ALLPASS_COUNT];
    logic [CI_W-1:0] r_ci;
    logic [AI_W-1:0] r_ai;
    logic [CLR_W-1:0] r_clr;
    logic        r_out_v;
    t_mac_cmd    mac;
    logic signed [47:0] acc, rnd;

    logic            c_we, a_we;
    logic [CA_W-1:0] c_addr;
    logic [AA_W-1:0] a_addr;
    logic [23:0]     c_wd, a_wd, c_rd, a_rd;

    car_ram #(.WIDTH(MEM_W), .DEPTH(COMB_COUNT * COMB_MAX_LENGTH)) u_comb (
        .i_clk(i_clk), .i_we(c_we), .i_addr(c_addr), .i_wdata(c_wd), .o_rdata(c_rd));
    car_ram #(.WIDTH(MEM_W), .DEPTH(ALLPASS_COUNT * ALLPASS_MAX_LENGTH)) u_ap (
        .i_clk(i_clk), .i_we(a_we), .i_addr(a_addr), .i_wdata(a_wd), .o_rdata(a_rd));
    car_mac u_mac (.i_clk(i_clk), .i_cmd(mac), .o_acc(acc));

    // round half up of acc / 2^16
    assign rnd = (acc + 48'sd32768) >>> 16;

    // APB
    assign pready = 1'b1;
    always_comb begin
        case (paddr[3:2])
            REG_MIX:   prdata = {15'd0, r_mix};
            REG_DECAY: prdata = {15'd0, r_decay};
            REG_DAMP:  prdata = {15'd0, r_damp};
            default:   prdata = 32'd0;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix <= 17'd0; r_decay <= 17'd32768; r_damp <= 17'd32768;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_MIX:   r_mix   <= pwdata[16:0];
                REG_DECAY: r_decay <= pwdata[16:0];
                REG_DAMP:  r_damp  <= pwdata[16:0];
                default:   ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_dout;

    logic [16:0] tgt;
    logic signed [18:0] diff;
    assign tgt  = clamp_unity(r_mix);
    assign diff = $signed({2'b0, tgt}) - $signed({2'b0, r_smix});

    // smoother step, at least one toward the target
    logic signed [18:0] mix_step;
    logic [16:0]        n_smix;
    always_comb begin
        mix_step = 19'(rnd);
        if (mix_step == 19'sd0 && diff != 19'sd0) mix_step = diff[18] ? -19'sd1 : 19'sd1;
        n_smix = 17'($signed({2'b0, r_smix}) + mix_step);
    end

    // memory addresses and write data
    always_comb begin
        c_we = 1'b0; a_we = 1'b0;
        c_addr = CA_W'(r_ci) * CA_W'(COMB_MAX_LENGTH) + CA_W'(r_cpos[r_ci]);
        a_addr = AA_W'(r_ai) * AA_W'(ALLPASS_MAX_LENGTH) + AA_W'(r_apos[r_ai]);
        c_wd = sat24(48'(r_x) + rnd);
        a_wd = sat24(48'(r_wet) + ((48'(r_tap) + 48'sd1) >>> 1));
        if (r_state == S_CLEAR) begin
            c_we = (CLR_W'(r_clr) < CLR_W'(COMB_COUNT * COMB_MAX_LENGTH));
            a_we = (CLR_W'(r_clr) < CLR_W'(ALLPASS_COUNT * ALLPASS_MAX_LENGTH));
            c_addr = r_clr[CA_W-1:0]; a_addr = r_clr[AA_W-1:0];
            c_wd = 24'd0; a_wd = 24'd0;
        end else if (r_state == S_CFBW && r_wait == 3'd1) begin
            c_we = 1'b1;
        end else if (r_state == S_AWR) begin
            a_we = 1'b1;
        end
    end

    // MAC commands
    always_comb begin
        mac = '0;
        case (r_state)
            S_MIX: begin
                mac.en = 1'b1; mac.clr = 1'b1;
                mac.a = 28'(diff); mac.b = 18'(MIX_GAIN);
            end
            S_COEF: begin
                mac.en = 1'b1; mac.clr = 1'b1;
                mac.a = 28'(clamp_unity(r_damp)); mac.b = 18'(DAMP_SPAN);
            end
            S_CLP: begin
                if (r_wait == 3'd0) begin
                    mac.en = 1'b1; mac.clr = 1'b1;
                    mac.a = 28'(r_tap); mac.b = 18'(UNITY - r_d);
                end else if (r_wait == 3'd1) begin
                    mac.en = 1'b1;
                    mac.a = 28'(r_lp[r_ci]); mac.b = 18'(r_d);
                end
            end
            S_CFB: begin
                mac.en = 1'b1; mac.clr = 1'b1;
                mac.a = 28'(r_lp[r_ci]); mac.b = 18'(r_fb);
            end
            S_OUT: begin
                if (r_wait == 3'd0) begin
                    mac.en = 1'b1; mac.clr = 1'b1;
                    mac.a = 28'(r_x); mac.b = 18'(UNITY - r_smix);
                end else if (r_wait == 3'd1) begin
                    mac.en = 1'b1;
                    mac.a = (r_wet + 28'sd1) >>> 1; mac.b = 18'(r_smix);
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_smix <= 17'd0; r_out_v <= 1'b0;
            r_wait <= '0; r_ci <= '0; r_ai <= '0;
            for (int i = 0; i < COMB_COUNT; i++) begin r_cpos[i] <= '0; r_lp[i] <= '0; end
            for (int i = 0; i < ALLPASS_COUNT; i++) r_apos[i] <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLR_W'(CLR_N - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (s_axis_tvalid) begin
                    r_x <= s_axis_tdata; r_wait <= '0; r_state <= S_MIX;
                end
                S_MIX: r_state <= S_MIXW;
                S_MIXW: begin
                    if (r_wait == 3'd1) begin
                        r_smix <= n_smix;
                        r_wait <= '0;
                        if (n_smix == 17'd0) begin
                            r_y <= r_x; r_state <= S_SEND;
                        end else begin
                            r_state <= S_COEF;
                        end
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                S_COEF: r_state <= S_COEFW;
                S_COEFW: begin
                    if (r_wait == 3'd1) begin
                        r_d  <= DAMP_BASE + 17'(rnd);
                        r_fb <= 17'd32768 + (clamp_unity(r_decay) >> 1);
                        r_wet <= '0; r_ci <= '0; r_wait <= '0; r_state <= S_CRD;
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                S_CRD: begin
                    if (r_wait == 3'd1) begin
                        r_tap <= c_rd; r_wet <= r_wet + 28'($signed(c_rd));
                        r_wait <= '0; r_state <= S_CLP;
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                S_CLP: begin
                    if (r_wait == 3'd4) begin
                        r_lp[r_ci] <= sat24(rnd); r_wait <= '0; r_state <= S_CFB;
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                // feedback product issued; comb written once the MAC accumulator holds it
                S_CFB: r_state <= S_CFBW;
                S_CFBW: begin
                    if (r_wait == 3'd1) begin
                        r_cpos[r_ci] <= (r_cpos[r_ci] == CP_W'(COMB_MAX_LENGTH - 1))
                                      ? '0 : r_cpos[r_ci] + 1'b1;
                        r_wait <= '0;
                        if (r_ci == CI_W'(COMB_COUNT - 1)) begin
                            r_ai <= '0; r_state <= S_ARD;
                        end else begin
                            r_ci <= r_ci + 1'b1; r_state <= S_CRD;
                        end
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                S_ARD: begin
                    if (r_wait == 3'd1) begin
                        r_tap <= a_rd; r_wait <= '0; r_state <= S_AWR;
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                S_AWR: begin
                    r_wet <= r_wet - 28'($signed(r_tap));
                    r_apos[r_ai] <= (r_apos[r_ai] == AP_W'(ALLPASS_MAX_LENGTH - 1))
                                  ? '0 : r_apos[r_ai] + 1'b1;
                    r_wait <= '0;
                    if (r_ai == AI_W'(ALLPASS_COUNT - 1)) r_state <= S_OUT;
                    else begin r_ai <= r_ai + 1'b1; r_state <= S_ARD; end
                end
                S_OUT: begin
                    if (r_wait == 3'd1) begin r_wait <= '0; r_state <= S_OUTW; end
                    else r_wait <= r_wait + 1'b1;
                end
                S_OUTW: begin
                    if (r_wait == 3'd2) begin
                        r_y <= sat16(rnd); r_wait <= '0; r_state <= S_SEND;
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                S_SEND: if (!r_out_v || m_axis_tready) begin
                    r_dout <= r_y; r_state <= S_IDLE;
                end
                default: ;
            endcase
            // output register
            if (r_state == S_SEND && (!r_out_v || m_axis_tready)) r_out_v <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_out_v <= 1'b0;
        end
    end
endmodule

### hw/rtl/car_ram.sv
// Generic single-port RAM with registered read.
module car_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

### hw/rtl/car_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate.
module car_mac
    import car_pkg::*;
(
    input  logic               i_clk,
    input  t_mac_cmd           i_cmd,
    output logic signed [47:0] o_acc
);
    logic signed [45:0] r_prod;
    logic               r_en, r_clr;

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_cmd.a * i_cmd.b;
        r_en   <= i_cmd.en;
        r_clr  <= i_cmd.clr;
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (r_en) o_acc <= (r_clr ? 48'sd0 : o_acc) + 48'(r_prod);
    end
endmodule
